>>> rtl/pss_pkg.sv
package pss_pkg;

    // fixed field widths
    localparam int PREFIX_BYTES = 8;
    localparam int WINDOW_W     = 8 * PREFIX_BYTES;
    localparam int COUNT_W      = 32;
    localparam int SLOT_W       = 4;
    localparam int TYPE_W       = 2;
    localparam int KIND_W       = 2;

    // table size default and the most slots an entry_slot word can reach
    localparam int NUM_ENTRIES_DEFAULT = 16;
    localparam int SLOT_REACH          = 1 << SLOT_W;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input word kinds
    localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;

    // register indexes
    localparam logic REG_OBJECT_TYPE = 1'b0;
    localparam logic REG_FILE_SIZE   = 1'b1;

    // one job for the back part: a window to match or a table entry to load
    typedef struct packed {
        logic                is_load;
        logic [WINDOW_W-1:0] word;
        logic [COUNT_W-1:0]  offset;
        logic [SLOT_W-1:0]   slot;
        logic [31:0]         first;
        logic [31:0]         last;
        logic [31:0]         length;
        logic [TYPE_W-1:0]   otype;
        logic                enable;
    } pss_job_t;

    // scan configuration seen by the back part
    typedef struct packed {
        logic [TYPE_W-1:0] otype;
        logic [31:0]       file_size;
    } pss_cfg_t;

endpackage

>>> rtl/prefix_signature_scanner_core.sv
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    kind, data_byte, entry_* fields
// output    out        out_valid / out_ready  hit_slot, hit_offset
// config    in/out     psel, penable, pwrite  paddr, pwdata, prdata, pready
//
// one word is taken per cycle while the job queue is not full; a scan byte enters the job queue at the
// edge that takes it and moves on to the output register when popped (slot compare in the back)
// the two-entry job queue between front and back absorbs output stalls
// loads and start words produce no result; warm-up bytes produce none either
// reset clears window, counter, queue, output and the table enable bits
module prefix_signature_scanner_core #(
    parameter int NUM_ENTRIES = pss_pkg::NUM_ENTRIES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pss_pkg::KIND_W-1:0]   kind,
    input  logic [7:0]                   data_byte,
    input  logic [pss_pkg::SLOT_W-1:0]   entry_slot,
    input  logic [pss_pkg::WINDOW_W-1:0] entry_prefix,
    input  logic [31:0]                  entry_first_offset,
    input  logic [31:0]                  entry_last_offset,
    input  logic [31:0]                  entry_length,
    input  logic [pss_pkg::TYPE_W-1:0]   entry_object_type,
    input  logic                         entry_enable,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pss_pkg::SLOT_W-1:0]   hit_slot,
    output logic [31:0]                  hit_offset,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [pss_pkg::TYPE_W-1:0] otype_reg, otype_next;
    logic [31:0]                fsize_reg, fsize_next;
    logic                       cfg_wr;
    pss_pkg::pss_cfg_t          cfg;

    logic              q_full;
    logic              push;
    pss_pkg::pss_job_t push_job;
    logic              pop;
    logic              head_valid;
    pss_pkg::pss_job_t head_job;

    // config register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        otype_next = otype_reg;
        fsize_next = fsize_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                pss_pkg::REG_OBJECT_TYPE: otype_next = pwdata[pss_pkg::TYPE_W-1:0];
                pss_pkg::REG_FILE_SIZE:   fsize_next = pwdata;
                default:                  fsize_next = fsize_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            pss_pkg::REG_OBJECT_TYPE: prdata = {{(32 - pss_pkg::TYPE_W){1'b0}}, otype_reg};
            pss_pkg::REG_FILE_SIZE:   prdata = fsize_reg;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            otype_reg <= '0;
            fsize_reg <= '0;
        end
        else
        begin
            otype_reg <= otype_next;
            fsize_reg <= fsize_next;
        end
    end

    assign cfg.otype     = otype_reg;
    assign cfg.file_size = fsize_reg;

    // front: window, counter, word classification
    pss_front #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .kind               (kind),
        .data_byte          (data_byte),
        .entry_slot         (entry_slot),
        .entry_prefix       (entry_prefix),
        .entry_first_offset (entry_first_offset),
        .entry_last_offset  (entry_last_offset),
        .entry_length       (entry_length),
        .entry_object_type  (entry_object_type),
        .entry_enable       (entry_enable),
        .q_full             (q_full),
        .push               (push),
        .push_job           (push_job)
    );

    // job queue
    pss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: table, slot compare, result register
    pss_back #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit_slot   (hit_slot),
        .hit_offset (hit_offset)
    );

endmodule

>>> rtl/pss_front.sv
module pss_front #(
    parameter int NUM_ENTRIES = pss_pkg::NUM_ENTRIES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pss_pkg::KIND_W-1:0]   kind,
    input  logic [7:0]                   data_byte,
    input  logic [pss_pkg::SLOT_W-1:0]   entry_slot,
    input  logic [pss_pkg::WINDOW_W-1:0] entry_prefix,
    input  logic [31:0]                  entry_first_offset,
    input  logic [31:0]                  entry_last_offset,
    input  logic [31:0]                  entry_length,
    input  logic [pss_pkg::TYPE_W-1:0]   entry_object_type,
    input  logic                         entry_enable,
    input  logic                         q_full,
    output logic                         push,
    output pss_pkg::pss_job_t            push_job
);

    localparam int WW = pss_pkg::WINDOW_W;
    localparam int CW = pss_pkg::COUNT_W;

    logic [WW-1:0] window_reg, window_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] count_inc;
    logic          accept;
    logic          slot_ok;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // saturating byte count after this byte
    assign count_inc = (count_reg == {CW{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign slot_ok   = 32'(entry_slot) < 32'(NUM_ENTRIES);

    // classify the word: update window state, build the job
    always_comb
    begin
        window_next       = window_reg;
        count_next        = count_reg;
        push              = 1'b0;
        push_job          = '0;
        push_job.word     = {data_byte, window_reg[WW-1:8]};
        push_job.offset   = count_inc - CW'(pss_pkg::PREFIX_BYTES);
        push_job.slot     = entry_slot;
        push_job.first    = entry_first_offset;
        push_job.last     = entry_last_offset;
        push_job.length   = entry_length;
        push_job.otype    = entry_object_type;
        push_job.enable   = entry_enable;
        if (accept)
        begin
            unique case (kind)
                pss_pkg::KIND_SCAN:
                begin
                    window_next = {data_byte, window_reg[WW-1:8]};
                    count_next  = count_inc;
                    push        = count_inc >= CW'(pss_pkg::PREFIX_BYTES);
                end
                pss_pkg::KIND_LOAD:
                begin
                    push_job.is_load = 1'b1;
                    push_job.word    = entry_prefix;
                    push             = slot_ok;
                end
                pss_pkg::KIND_START:
                begin
                    window_next = '0;
                    count_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // window and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/pss_queue.sv
module pss_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pss_pkg::pss_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output pss_pkg::pss_job_t head_job
);

    localparam int DEPTH = pss_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    pss_pkg::pss_job_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign full       = fill_reg == NW'(DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/pss_back.sv
module pss_back #(
    parameter int NUM_ENTRIES = pss_pkg::NUM_ENTRIES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pss_pkg::pss_cfg_t          cfg,
    input  logic                       head_valid,
    input  pss_pkg::pss_job_t          head_job,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [pss_pkg::SLOT_W-1:0] hit_slot,
    output logic [31:0]                hit_offset
);

    // slots beyond what entry_slot can address never hold anything
    localparam int DEPTH = (NUM_ENTRIES < pss_pkg::SLOT_REACH) ?
                           NUM_ENTRIES : pss_pkg::SLOT_REACH;
    localparam int SW    = pss_pkg::SLOT_W;
    localparam int WW    = pss_pkg::WINDOW_W;
    localparam int TW    = pss_pkg::TYPE_W;

    logic [WW-1:0] prefix_reg [DEPTH];
    logic [31:0]   first_reg  [DEPTH];
    logic [31:0]   last_reg   [DEPTH];
    logic [31:0]   length_reg [DEPTH];
    logic [TW-1:0] type_reg   [DEPTH];
    logic [DEPTH-1:0] enable_reg, enable_next;

    logic [DEPTH-1:0] slot_hit;
    logic [DEPTH-1:0] slot_wr;
    logic             any_hit;
    logic [SW-1:0]    hit_idx;

    logic          out_valid_reg, out_valid_next;
    logic [SW-1:0] hit_slot_reg, hit_slot_next;
    logic [31:0]   hit_offset_reg, hit_offset_next;

    assign pop        = head_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign hit_slot   = hit_slot_reg;
    assign hit_offset = hit_offset_reg;

    // per-slot match checks, all slots side by side
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_hit[i] = enable_reg[i]
                       && (prefix_reg[i] == head_job.word)
                       && (type_reg[i] == cfg.otype)
                       && (head_job.offset >= first_reg[i])
                       && (head_job.offset <= last_reg[i])
                       && (length_reg[i] >= 32'(pss_pkg::PREFIX_BYTES))
                       && (({1'b0, head_job.offset} + {1'b0, length_reg[i]})
                           <= {1'b0, cfg.file_size});
            slot_wr[i]  = pop && head_job.is_load && (head_job.slot == SW'(i));
        end
    end

    // lowest hitting slot
    always_comb
    begin
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (slot_hit[i])
                hit_idx = SW'(i);
        end
    end

    assign any_hit = |slot_hit;

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        hit_slot_next   = hit_slot_reg;
        hit_offset_next = hit_offset_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (pop && !head_job.is_load && any_hit)
        begin
            out_valid_next  = 1'b1;
            hit_slot_next   = hit_idx;
            hit_offset_next = head_job.offset;
        end
    end

    // enable bits per slot
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            enable_next[i] = slot_wr[i] ? head_job.enable : enable_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            enable_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            enable_reg    <= enable_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        hit_slot_reg   <= hit_slot_next;
        hit_offset_reg <= hit_offset_next;
    end

    // table entry fields
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_wr[i])
            begin
                prefix_reg[i] <= head_job.word;
                first_reg[i]  <= head_job.first;
                last_reg[i]   <= head_job.last;
                length_reg[i] <= head_job.length;
                type_reg[i]   <= head_job.otype;
            end
        end
    end

endmodule

>>> test/prefix_signature_scanner_checker.sv
module prefix_signature_scanner_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [pss_pkg::KIND_W-1:0]   kind,
    input  logic [7:0]                   data_byte,
    input  logic [pss_pkg::SLOT_W-1:0]   entry_slot,
    input  logic [pss_pkg::WINDOW_W-1:0] entry_prefix,
    input  logic [31:0]                  entry_first_offset,
    input  logic [31:0]                  entry_last_offset,
    input  logic [31:0]                  entry_length,
    input  logic [pss_pkg::TYPE_W-1:0]   entry_object_type,
    input  logic                         entry_enable,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [pss_pkg::SLOT_W-1:0]   hit_slot,
    input  logic [31:0]                  hit_offset,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         pready,
    output int                           mismatch_count,
    output int                           hits_outstanding
);

    import pss_pkg::*;

    localparam int NUM_SLOTS = NUM_ENTRIES_DEFAULT;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       offset;
    } hit_t;

    // own copy of the scanner state and configuration
    logic [WINDOW_W-1:0] scan_window;
    logic [31:0]         scan_count;
    logic [WINDOW_W-1:0] sig_prefix [NUM_SLOTS];
    logic [31:0]         sig_first  [NUM_SLOTS];
    logic [31:0]         sig_last   [NUM_SLOTS];
    logic [31:0]         sig_length [NUM_SLOTS];
    logic [TYPE_W-1:0]   sig_type   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] sig_enable;
    logic [TYPE_W-1:0]   cfg_type;
    logic [31:0]         cfg_size;

    // hits still to come out of the block, oldest first
    hit_t hits_due [$];
    hit_t due;
    int   fails = 0;

    // one slot against the current window and a candidate start offset
    function automatic bit slot_accepts(int s, logic [31:0] off);
        logic [32:0] reach;
        reach = {1'b0, off} + {1'b0, sig_length[s]};
        return sig_enable[s] && (sig_prefix[s] == scan_window) && (sig_type[s] == cfg_type)
            && (off >= sig_first[s]) && (off <= sig_last[s])
            && (sig_length[s] >= 32'(PREFIX_BYTES)) && (reach <= {1'b0, cfg_size});
    endfunction

    // advance the state by one accepted input word
    task automatic absorb_word();
        logic [31:0] start_off;
        hit_t        h;
        bit          found;
        found = 1'b0;
        case (kind)
            KIND_SCAN:
            begin
                scan_window = {data_byte, scan_window[WINDOW_W-1:8]};
                if (scan_count != '1)
                    scan_count = scan_count + 32'd1;
                if (scan_count >= 32'(PREFIX_BYTES))
                begin
                    start_off = scan_count - 32'(PREFIX_BYTES);
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        if (!found && slot_accepts(s, start_off))
                        begin
                            h.slot   = SLOT_W'(s);
                            h.offset = start_off;
                            hits_due.insert(hits_due.size(), h);
                            found = 1'b1;
                        end
                    end
                end
            end
            KIND_LOAD:
            begin
                if (int'(entry_slot) < NUM_SLOTS)
                begin
                    sig_prefix[entry_slot] = entry_prefix;
                    sig_first[entry_slot]  = entry_first_offset;
                    sig_last[entry_slot]   = entry_last_offset;
                    sig_length[entry_slot] = entry_length;
                    sig_type[entry_slot]   = entry_object_type;
                    sig_enable[entry_slot] = entry_enable;
                end
            end
            KIND_START:
            begin
                scan_window = '0;
                scan_count  = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_window = '0;
            scan_count  = '0;
            sig_enable  = '0;
            cfg_type    = '0;
            cfg_size    = '0;
            hits_due.delete();
            hits_outstanding <= 0;
            mismatch_count   <= fails;
        end
        else
        begin
            // result word leaving the block
            if (out_valid && out_ready)
            begin
                if (hits_due.size() == 0)
                begin
                    $error("unexpected result word: hit_slot %0d hit_offset %0d",
                           hit_slot, hit_offset);
                    fails++;
                end
                else
                begin
                    due = hits_due.pop_front();
                    if (hit_slot !== due.slot)
                    begin
                        $error("hit_slot mismatch: expected %0d, actual %0d",
                               due.slot, hit_slot);
                        fails++;
                    end
                    if (hit_offset !== due.offset)
                    begin
                        $error("hit_offset mismatch: expected %0d, actual %0d",
                               due.offset, hit_offset);
                        fails++;
                    end
                end
            end

            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_OBJECT_TYPE: cfg_type = pwdata[TYPE_W-1:0];
                    REG_FILE_SIZE:   cfg_size = pwdata;
                    default:
                    begin
                    end
                endcase
            end

            // input word entering the block
            if (in_valid && in_ready)
                absorb_word();

            hits_outstanding <= hits_due.size();
            mismatch_count   <= fails;
        end
    end

endmodule

>>> test/tb_prefix_signature_scanner_core.sv
module tb_prefix_signature_scanner_core;

    import pss_pkg::*;

    localparam int SLOTS         = NUM_ENTRIES_DEFAULT;
    localparam int PHASE_WORDS   = 82;
    localparam int LONG_HOLD     = 120;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [2:0]        ADDR_OBJECT_TYPE = {REG_OBJECT_TYPE, 2'b00};
    localparam logic [2:0]        ADDR_FILE_SIZE   = {REG_FILE_SIZE, 2'b00};
    localparam logic [KIND_W-1:0] KIND_UNUSED      = 2'd3;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                clk                = 1'b0;
    logic                rst_n              = 1'b0;
    logic                in_valid           = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind               = '0;
    logic [7:0]          data_byte          = '0;
    logic [SLOT_W-1:0]   entry_slot         = '0;
    logic [WINDOW_W-1:0] entry_prefix       = '0;
    logic [31:0]         entry_first_offset = '0;
    logic [31:0]         entry_last_offset  = '0;
    logic [31:0]         entry_length       = '0;
    logic [TYPE_W-1:0]   entry_object_type  = '0;
    logic                entry_enable       = 1'b0;
    logic                out_valid;
    logic                out_ready          = 1'b0;
    logic [SLOT_W-1:0]   hit_slot;
    logic [31:0]         hit_offset;
    logic                psel               = 1'b0;
    logic                penable            = 1'b0;
    logic                pwrite             = 1'b0;
    logic [2:0]          paddr              = '0;
    logic [31:0]         pwdata             = '0;
    logic [31:0]         prdata;
    logic                pready;

    int mismatch_count;
    int hits_outstanding;

    // sender bookkeeping
    int                  burst_left  = 0;
    int                  words_sent  = 0;
    logic [TYPE_W-1:0]   cur_type    = '0;
    logic [WINDOW_W-1:0] known_prefix [SLOTS];
    bit                  known_valid  [SLOTS];

    // receiver pattern and long hold requests
    int       hold_asked  = 0;
    int       hold_served = 0;
    int       stall_left  = 0;
    int       rx_left     = 0;
    int       rx_tick     = 0;
    rx_mode_t rx_mode     = RX_FREE;

    always #5 clk = ~clk;

    prefix_signature_scanner_core uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .kind               (kind),
        .data_byte          (data_byte),
        .entry_slot         (entry_slot),
        .entry_prefix       (entry_prefix),
        .entry_first_offset (entry_first_offset),
        .entry_last_offset  (entry_last_offset),
        .entry_length       (entry_length),
        .entry_object_type  (entry_object_type),
        .entry_enable       (entry_enable),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .hit_slot           (hit_slot),
        .hit_offset         (hit_offset),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    prefix_signature_scanner_checker hit_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .kind               (kind),
        .data_byte          (data_byte),
        .entry_slot         (entry_slot),
        .entry_prefix       (entry_prefix),
        .entry_first_offset (entry_first_offset),
        .entry_last_offset  (entry_last_offset),
        .entry_length       (entry_length),
        .entry_object_type  (entry_object_type),
        .entry_enable       (entry_enable),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .hit_slot           (hit_slot),
        .hit_offset         (hit_offset),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .mismatch_count     (mismatch_count),
        .hits_outstanding   (hits_outstanding)
    );

    // receiver: long holds on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            out_ready   <= 1'b0;
            stall_left  <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(16, 160);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_FREE:   out_ready <= 1'b1;
                RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= ((rx_tick % 5) < 3);
            endcase
        end
        rx_tick <= rx_tick + 1;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // one register write: setup, access, then idle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // offer one input word in bursts with random gaps, wait until taken
    task automatic send_word(input logic [KIND_W-1:0] k, input logic [7:0] b,
                             input logic [SLOT_W-1:0] s, input logic [WINDOW_W-1:0] p,
                             input logic [31:0] f, input logic [31:0] l,
                             input logic [31:0] len, input logic [TYPE_W-1:0] t,
                             input logic e);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        in_valid           <= 1'b1;
        kind               <= k;
        data_byte          <= b;
        entry_slot         <= s;
        entry_prefix       <= p;
        entry_first_offset <= f;
        entry_last_offset  <= l;
        entry_length       <= len;
        entry_object_type  <= t;
        entry_enable       <= e;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        if (k != KIND_UNUSED)
            words_sent++;
    endtask

    task automatic scan_byte(input logic [7:0] b);
        send_word(KIND_SCAN, b, SLOT_W'($urandom), {$urandom, $urandom}, $urandom,
                  $urandom, $urandom, TYPE_W'($urandom_range(0, 2)), 1'($urandom));
    endtask

    task automatic start_scan();
        send_word(KIND_START, 8'($urandom), SLOT_W'($urandom), {$urandom, $urandom},
                  $urandom, $urandom, $urandom, TYPE_W'($urandom_range(0, 2)),
                  1'($urandom));
    endtask

    task automatic unused_word();
        send_word(KIND_UNUSED, 8'($urandom), SLOT_W'($urandom), {$urandom, $urandom},
                  $urandom, $urandom, $urandom, TYPE_W'($urandom_range(0, 2)),
                  1'($urandom));
    endtask

    task automatic load_entry(input logic [SLOT_W-1:0] s, input logic [WINDOW_W-1:0] p,
                              input logic [31:0] f, input logic [31:0] l,
                              input logic [31:0] len, input logic [TYPE_W-1:0] t,
                              input logic e);
        send_word(KIND_LOAD, 8'($urandom), s, p, f, l, len, t, e);
        known_prefix[s] = p;
        known_valid[s]  = 1'b1;
    endtask

    // mostly well-formed entries with wide windows, some that must fail a check
    task automatic load_random_entry();
        logic [SLOT_W-1:0]   s;
        logic [WINDOW_W-1:0] p;
        logic [31:0]         f;
        logic [31:0]         l;
        logic [31:0]         len;
        logic [TYPE_W-1:0]   t;
        int                  other;
        s     = SLOT_W'($urandom_range(0, SLOTS - 1));
        other = $urandom_range(0, SLOTS - 1);
        case ($urandom_range(0, 9))
            0, 1:    p = known_valid[other] ? known_prefix[other] : {$urandom, $urandom};
            2:       p = {8{8'($urandom)}};
            default: p = {$urandom, $urandom};
        endcase
        f = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 24)) : $urandom;
        case ($urandom_range(0, 3))
            0:       l = '1;
            1:       l = f + 32'($urandom_range(0, 60));
            2:       l = f;
            default: l = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       len = 32'($urandom_range(0, 7));
            1:       len = 32'd8;
            2, 3:    len = 32'($urandom_range(8, 64));
            4:       len = $urandom;
            default: len = '1;
        endcase
        t = ($urandom_range(0, 3) != 0) ? cur_type : TYPE_W'($urandom_range(0, 2));
        load_entry(s, p, f, l, len, t, 1'($urandom_range(0, 6) != 0));
    endtask

    // stream the first n bytes of a loaded prefix, lowest byte first
    task automatic stream_prefix(input int s, input int n);
        for (int i = 0; i < n; i++)
            scan_byte(known_prefix[s][8*i +: 8]);
    endtask

    // stop offering and wait for every expected hit, then let the pipe settle
    task automatic rest_and_drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (hits_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // a hit on every byte after warm-up while the receiver holds off, so the block backs up
    task automatic squeeze_output();
        load_entry(0, {8{8'hAA}}, 32'd0, '1, 32'd8, cur_type, 1'b1);
        start_scan();
        hold_asked <= hold_asked + 1;
        repeat (30) scan_byte(8'hAA);
    endtask

    // one configuration setting followed by random traffic
    task automatic run_phase(input logic [TYPE_W-1:0] t, input logic [31:0] size,
                             input bit squeeze);
        int s;
        rest_and_drain();
        reg_write(ADDR_OBJECT_TYPE, 32'(t));
        reg_write(ADDR_FILE_SIZE, size);
        cur_type   = t;
        words_sent = 0;
        start_scan();
        repeat (4) load_random_entry();
        if (squeeze)
            squeeze_output();
        while (words_sent < PHASE_WORDS)
        begin
            case ($urandom_range(0, 99)) inside
                [0:7]:   load_random_entry();
                [8:12]:  start_scan();
                [13:15]: unused_word();
                [16:59]:
                begin
                    s = $urandom_range(0, SLOTS - 1);
                    if (known_valid[s])
                        stream_prefix(s, ($urandom_range(0, 4) == 0) ?
                                         $urandom_range(1, 7) : 8);
                    else
                        scan_byte(8'($urandom));
                end
                default: repeat ($urandom_range(1, 6)) scan_byte(8'($urandom));
            endcase
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            known_valid[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: warm-up, lowest slot wins, offset window, unused kind
        reg_write(ADDR_OBJECT_TYPE, 32'd1);
        reg_write(ADDR_FILE_SIZE, '1);
        cur_type = 2'd1;
        load_entry(4'd15, 64'h0807060504030201, 32'd0, '1, 32'd8, 2'd1, 1'b1);
        load_entry(4'd3, 64'h0807060504030201, 32'd0, 32'd0, '1, 2'd1, 1'b1);
        start_scan();
        for (int i = 1; i <= 8; i++)
            scan_byte(8'(i));
        for (int i = 1; i <= 8; i++)
            scan_byte(8'(i));
        unused_word();
        load_entry(4'd0, '1, '1, '1, '1, 2'd2, 1'b0);
        scan_byte(8'hFF);
        scan_byte(8'h00);

        // random phases over several settings, size extremes included
        run_phase(2'd0, '1, 1'b1);
        run_phase(2'd2, 32'($urandom_range(200, 3000)), 1'b0);
        run_phase(2'd1, 32'd0, 1'b0);
        run_phase(2'd1, 32'($urandom_range(40, 90)), 1'b1);
        run_phase(2'd2, $urandom, 1'b0);

        rest_and_drain();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
